[hw/rtl/rcv_pkg.sv]
package rcv_pkg;

   localparam int FWID_W    = 11;
   localparam int HGT_W     = 13;
   localparam int ROW_W     = 12;
   localparam int MAX_HEIGHT = 4096;
   localparam int TAP_W     = 12;
   localparam int TAP_ROWS  = 3;
   localparam int TAP_ROW_W = 36;
   localparam int PIX_W     = 24;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 36;

   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_DRAIN = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TAPS_TOP     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TAPS_MIDDLE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TAPS_BOTTOM  = 3'd4;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             emit;
      logic [8:0]       tap_en;
      logic             frame_end;
   } cmd_type;

   localparam int CMD_W = $bits(cmd_type);

endpackage

[hw/rtl/rcv_front.sv]
module rcv_front #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [rcv_pkg::FWID_W-1:0]  frame_width,
   input  logic [rcv_pkg::HGT_W-1:0]   frame_height,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_type,
   input  logic [7:0]                  req_in_red,
   input  logic [7:0]                  req_in_green,
   input  logic [7:0]                  req_in_blue,
   input  logic                        q_full,
   output logic                        q_push,
   output logic [$clog2(MAX_WIDTH)-1:0] q_col,
   output rcv_pkg::cmd_type            q_cmd
);
   import rcv_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WW    = COL_W + 1;
   localparam int CNT_W = COL_W + 2;

   logic [13:0]       w_full;
   logic [WW-1:0]     w_eff;
   logic [HGT_W-1:0]  h_eff;

   logic [COL_W-1:0]  in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [ROW_W-1:0]  in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [CNT_W-1:0]  lead_ff, lead_in, real_ff, real_in;

   logic [COL_W-1:0]  in_col_adv, out_col_adv;
   logic [ROW_W-1:0]  in_row_adv, out_row_adv;
   logic [CNT_W-1:0]  limit, lead_inc;
   logic              fire, do_push, emit, is_drain;
   logic [2:0]        row_ok, col_ok;
   logic [WW-1:0]     ox_x;
   logic [HGT_W-1:0]  oy_x;

   always_comb begin
      if (frame_width == '0) begin
         w_full = 14'd1;
      end else if ({3'b0, frame_width} > 14'(MAX_WIDTH)) begin
         w_full = 14'(MAX_WIDTH);
      end else begin
         w_full = {3'b0, frame_width};
      end
      w_eff = w_full[WW-1:0];
      if (frame_height == '0) begin
         h_eff = HGT_W'(1);
      end else if (frame_height > HGT_W'(MAX_HEIGHT)) begin
         h_eff = HGT_W'(MAX_HEIGHT);
      end else begin
         h_eff = frame_height;
      end
   end

   // raster advance with wrap at the effective size
   always_comb begin
      if ({1'b0, in_col_ff} + WW'(1) >= w_eff) begin
         in_col_adv = '0;
         in_row_adv = ({1'b0, in_row_ff} + HGT_W'(1) >= h_eff) ? '0 : in_row_ff + ROW_W'(1);
      end else begin
         in_col_adv = in_col_ff + COL_W'(1);
         in_row_adv = in_row_ff;
      end
      if ({1'b0, out_col_ff} + WW'(1) >= w_eff) begin
         out_col_adv = '0;
         out_row_adv = ({1'b0, out_row_ff} + HGT_W'(1) >= h_eff) ? '0 : out_row_ff + ROW_W'(1);
      end else begin
         out_col_adv = out_col_ff + COL_W'(1);
         out_row_adv = out_row_ff;
      end
   end

   assign req_ready = !q_full;
   assign fire      = req_valid && req_ready;
   assign is_drain  = (req_type == REQ_DRAIN);
   assign do_push   = !is_drain || (real_ff != '0);
   assign limit     = {1'b0, w_eff} + CNT_W'(1);
   assign lead_inc  = lead_ff + CNT_W'(1);
   assign emit      = do_push && (lead_inc > limit);

   // border test for the output position
   assign ox_x = {1'b0, out_col_ff};
   assign oy_x = {1'b0, out_row_ff};
   always_comb begin
      row_ok[0] = (oy_x + HGT_W'(1)) < h_eff;
      row_ok[1] = oy_x < h_eff;
      row_ok[2] = (oy_x != '0) && (oy_x <= h_eff);
      col_ok[0] = (ox_x + WW'(1)) < w_eff;
      col_ok[1] = ox_x < w_eff;
      col_ok[2] = (ox_x != '0) && (ox_x <= w_eff);
      for (int r = 0; r < 3; r++) begin
         for (int s = 0; s < 3; s++) begin
            q_cmd.tap_en[r*3+s] = row_ok[r] && col_ok[s];
         end
      end
      q_cmd.pixel     = is_drain ? '0 : {req_in_blue, req_in_green, req_in_red};
      q_cmd.emit      = emit;
      q_cmd.frame_end = (ox_x == w_eff - WW'(1)) && (oy_x == h_eff - HGT_W'(1));
   end

   assign q_push = fire && do_push;
   assign q_col  = in_col_ff;

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      lead_in    = lead_ff;
      real_in    = real_ff;
      if (fire && do_push) begin
         in_col_in = in_col_adv;
         in_row_in = in_row_adv;
         if (emit) begin
            out_col_in = out_col_adv;
            out_row_in = out_row_adv;
            lead_in    = lead_ff;
            real_in    = is_drain ? real_ff - CNT_W'(1) : real_ff;
            // last waiting output flushed: restart input at output position
            if (is_drain && real_ff == CNT_W'(1)) begin
               in_col_in = out_col_adv;
               in_row_in = out_row_adv;
               lead_in   = '0;
            end
         end else begin
            lead_in = lead_inc;
            real_in = is_drain ? real_ff : real_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         lead_ff    <= '0;
         real_ff    <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         lead_ff    <= lead_in;
         real_ff    <= real_in;
      end
   end

endmodule

[hw/rtl/rcv_queue.sv]
module rcv_queue #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic              pop_valid,
   output logic [DATA_W-1:0] pop_data
);

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]    count_ff;
   logic              do_push, do_pop;

   assign full      = (count_ff == (PTR_W+1)'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         count_ff <= count_ff + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
      end
   end

endmodule

[hw/rtl/rcv_back.sv]
module rcv_back #(
   parameter int MAX_WIDTH      = 1024,
   parameter int COEF_FRAC_BITS = 8
) (
   input  logic                                                clock,
   input  logic                                                reset,
   input  logic [rcv_pkg::TAP_ROWS-1:0][rcv_pkg::TAP_ROW_W-1:0] taps,
   input  logic                                                q_valid,
   output logic                                                q_pop,
   input  logic [$clog2(MAX_WIDTH)-1:0]                        q_col,
   input  rcv_pkg::cmd_type                                    q_cmd,
   output logic                                                rsp_valid,
   input  logic                                                rsp_ready,
   output logic [7:0]                                          rsp_out_red,
   output logic [7:0]                                          rsp_out_green,
   output logic [7:0]                                          rsp_out_blue,
   output logic                                                rsp_frame_end
);
   import rcv_pkg::*;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int PROD_W = TAP_W + 9;
   localparam int SUM_W  = PROD_W + 4;

   logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
   logic [2*PIX_W-1:0] rd_ff;

   logic               adv;
   logic               b_valid_ff;
   logic [COL_W-1:0]   b_col_ff;
   cmd_type            b_cmd_ff;

   logic               last_valid_ff;
   logic [COL_W-1:0]   last_col_ff;
   logic [PIX_W-1:0]   last_up_ff, last_lo_ff;

   logic [PIX_W-1:0]   window_ff [9];
   logic [PIX_W-1:0]   window_in [9];
   logic [PIX_W-1:0]   above2, above1;
   logic               fwd;

   logic signed [PROD_W-1:0] prod_in [9][3];
   logic signed [PROD_W-1:0] c_prod_ff [9][3];
   logic               c_valid_ff, c_frame_end_ff;

   logic signed [SUM_W-1:0] sum [3];
   logic signed [SUM_W-1:0] shifted [3];
   logic [7:0]         chan [3];

   logic               rsp_valid_ff, rsp_frame_end_ff;
   logic [7:0]         rsp_red_ff, rsp_green_ff, rsp_blue_ff;

   assign adv   = !rsp_valid_ff || rsp_ready;
   assign q_pop = adv && q_valid;

   // the previous request is the latest writer of any column
   assign fwd    = last_valid_ff && (last_col_ff == b_col_ff);
   assign above2 = fwd ? last_up_ff : rd_ff[2*PIX_W-1:PIX_W];
   assign above1 = fwd ? last_lo_ff : rd_ff[PIX_W-1:0];

   always_comb begin
      for (int q = 0; q < 3; q++) begin
         window_in[q*3+2] = window_ff[q*3+1];
         window_in[q*3+1] = window_ff[q*3];
      end
      window_in[0] = above2;
      window_in[3] = above1;
      window_in[6] = b_cmd_ff.pixel;
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int s = 0; s < 3; s++) begin
            for (int c = 0; c < 3; c++) begin
               if (b_cmd_ff.tap_en[r*3+s]) begin
                  prod_in[r*3+s][c] = $signed(taps[r][TAP_W*s +: TAP_W])
                     * $signed({1'b0, window_in[(2-r)*3+s][8*c +: 8]});
               end else begin
                  prod_in[r*3+s][c] = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rd_ff <= line_mem[q_col];
      end
      if (adv && b_valid_ff) begin
         line_mem[b_col_ff] <= {above1, b_cmd_ff.pixel};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_col_ff <= q_col;
         b_cmd_ff <= q_cmd;
         c_prod_ff <= prod_in;
         c_frame_end_ff <= b_cmd_ff.frame_end;
      end
      if (adv && b_valid_ff) begin
         last_col_ff <= b_col_ff;
         last_up_ff  <= above1;
         last_lo_ff  <= b_cmd_ff.pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff    <= 1'b0;
         c_valid_ff    <= 1'b0;
         last_valid_ff <= 1'b0;
         for (int i = 0; i < 9; i++) begin
            window_ff[i] <= '0;
         end
      end else if (adv) begin
         b_valid_ff <= q_valid;
         c_valid_ff <= b_valid_ff && b_cmd_ff.emit;
         if (b_valid_ff) begin
            last_valid_ff <= 1'b1;
            window_ff     <= window_in;
         end
      end
   end

   // sum, drop fraction, clamp
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sum[c] = '0;
         for (int t = 0; t < 9; t++) begin
            sum[c] = sum[c] + SUM_W'(c_prod_ff[t][c]);
         end
         shifted[c] = sum[c] >>> COEF_FRAC_BITS;
         if (sum[c] < 0) begin
            chan[c] = 8'd0;
         end else if (shifted[c] > SUM_W'(255)) begin
            chan[c] = 8'd255;
         end else begin
            chan[c] = shifted[c][7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_red_ff       <= chan[0];
         rsp_green_ff     <= chan[1];
         rsp_blue_ff      <= chan[2];
         rsp_frame_end_ff <= c_frame_end_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= c_valid_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = rsp_red_ff;
   assign rsp_out_green = rsp_green_ff;
   assign rsp_out_blue  = rsp_blue_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

`ifndef SYNTHESIS
   a_b_hold: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && !adv) |=> (b_valid_ff && $stable(b_col_ff)))
      else $error("stage B changed while stalled");
   a_emit_reaches_c: assert property (@(posedge clock) disable iff (reset)
      (adv && b_valid_ff && b_cmd_ff.emit) |=> c_valid_ff)
      else $error("emitting request lost before sum stage");
   a_c_hold: assert property (@(posedge clock) disable iff (reset)
      (c_valid_ff && !adv) |=> c_valid_ff)
      else $error("sum stage dropped while stalled");
`endif

endmodule

[hw/rtl/rgb_convolution_3x3_unit.sv]
// channel  dir  handshake                 payload
// req      in   req_valid / req_ready     req_type, req_in_red/green/blue
// rsp      out  rsp_valid / rsp_ready     rsp_out_red/green/blue, rsp_frame_end
// csr      in   csr_write_enable          csr_index, csr_write_data
//
// One request per cycle sustained unless rsp stalls; a result passes the queue,
// line store read, multiply, and sum and clamp stages after its request.
// Line store is one memory with a read and a write port; a column written by
// the previous request is forwarded. Synchronous active-high reset; no clear pass.
// A stalled rsp freezes the back pipeline; the 4-entry queue keeps req open.
module rgb_convolution_3x3_unit #(
   parameter int MAX_WIDTH      = 1024,
   parameter int COEF_FRAC_BITS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_type,
   input  logic [7:0]                        req_in_red,
   input  logic [7:0]                        req_in_green,
   input  logic [7:0]                        req_in_blue,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_out_red,
   output logic [7:0]                        rsp_out_green,
   output logic [7:0]                        rsp_out_blue,
   output logic                              rsp_frame_end,
   input  logic                              csr_write_enable,
   input  logic [rcv_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rcv_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import rcv_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);

   logic [FWID_W-1:0]                    frame_width_ff;
   logic [HGT_W-1:0]                     frame_height_ff;
   logic [TAP_ROWS-1:0][TAP_ROW_W-1:0]   taps_ff;

   logic               q_push, q_full, q_pop, q_valid;
   logic [COL_W-1:0]   f_col, b_col;
   cmd_type            f_cmd, b_cmd;
   logic [COL_W+CMD_W-1:0] q_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FWID_W'(1024);
         frame_height_ff <= HGT_W'(768);
         taps_ff[0]      <= '0;
         taps_ff[1]      <= 36'h000100000;
         taps_ff[2]      <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_write_data[FWID_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_write_data[HGT_W-1:0];
            CSR_TAPS_TOP:     taps_ff[0]      <= csr_write_data;
            CSR_TAPS_MIDDLE:  taps_ff[1]      <= csr_write_data;
            CSR_TAPS_BOTTOM:  taps_ff[2]      <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   rcv_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock        (clock),
      .reset        (reset),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_type     (req_type),
      .req_in_red   (req_in_red),
      .req_in_green (req_in_green),
      .req_in_blue  (req_in_blue),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_col        (f_col),
      .q_cmd        (f_cmd)
   );

   rcv_queue #(.DATA_W(COL_W + CMD_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({f_col, f_cmd}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_out)
   );

   assign b_col = q_out[COL_W+CMD_W-1:CMD_W];
   assign b_cmd = q_out[CMD_W-1:0];

   rcv_back #(
      .MAX_WIDTH      (MAX_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .taps          (taps_ff),
      .q_valid       (q_valid),
      .q_pop         (q_pop),
      .q_col         (b_col),
      .q_cmd         (b_cmd),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

[test/tb_rgb_convolution_3x3_unit.sv]
module tb_rgb_convolution_3x3_unit;
   import rcv_pkg::*;

   localparam int LINE_DEPTH = 1024;
   localparam int FRAC_BITS  = 8;
   localparam int SETTLE     = 24;
   localparam int STALL_LIMIT = 4000;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       frame_end;
   } rgb_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_type = REQ_PIXEL;
   logic [7:0]            req_in_red = '0;
   logic [7:0]            req_in_green = '0;
   logic [7:0]            req_in_blue = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [7:0]            rsp_out_red;
   logic [7:0]            rsp_out_green;
   logic [7:0]            rsp_out_blue;
   logic                  rsp_frame_end;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   rgb_convolution_3x3_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_in_red(req_in_red), .req_in_green(req_in_green), .req_in_blue(req_in_blue),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_out_red(rsp_out_red), .rsp_out_green(rsp_out_green),
      .rsp_out_blue(rsp_out_blue), .rsp_frame_end(rsp_frame_end),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #4 clock = ~clock;

   // filter model state
   logic [10:0]        width_reg;
   logic [12:0]        height_reg;
   logic [35:0]        kernel_rows [3];
   logic [23:0]        upper_line [LINE_DEPTH];
   logic [23:0]        lower_line [LINE_DEPTH];
   logic [23:0]        window [9];
   int                 in_col, in_row, out_col, out_row, lead_cnt, pend_real;
   rgb_result_type     expected_pixels [$];

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  rsp_hold = 0;
   int  mismatches = 0;
   int  stall_cycles = 0;

   function automatic int active_width();
      if (width_reg == 0) return 1;
      if (width_reg > LINE_DEPTH) return LINE_DEPTH;
      return width_reg;
   endfunction

   function automatic int active_height();
      if (height_reg == 0) return 1;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return height_reg;
   endfunction

   // returns {row, col} of the next raster position
   function automatic logic [63:0] next_pos(int col, int row);
      if (col + 1 >= active_width())
         return {(row + 1 >= active_height()) ? 32'd0 : 32'(row + 1), 32'd0};
      return {32'(row), 32'(col + 1)};
   endfunction

   function automatic void shift_in(logic [23:0] pix);
      int col;
      logic [23:0] above2, above1;
      logic [63:0] pos;
      col = (in_col < LINE_DEPTH) ? in_col : 0;
      above2 = upper_line[col];
      above1 = lower_line[col];
      upper_line[col] = above1;
      lower_line[col] = pix;
      for (int q = 0; q < 3; q++) begin
         window[q*3+2] = window[q*3+1];
         window[q*3+1] = window[q*3];
      end
      window[0] = above2;
      window[3] = above1;
      window[6] = pix;
      pos = next_pos(in_col, in_row);
      in_col = pos[31:0];
      in_row = pos[63:32];
   endfunction

   function automatic void filter_out();
      int w, h, ox, oy;
      int sum [3];
      bit row_ok, col_ok;
      logic signed [11:0] k;
      logic [23:0] pix;
      logic [7:0] chan [3];
      logic [63:0] pos;
      w = active_width();
      h = active_height();
      ox = out_col;
      oy = out_row;
      sum = '{0, 0, 0};
      for (int r = 0; r < 3; r++) begin
         row_ok = (r == 0) ? (oy + 1 < h) : (r == 1) ? (oy < h) : (oy >= 1 && oy - 1 < h);
         for (int s = 0; s < 3; s++) begin
            col_ok = (s == 0) ? (ox + 1 < w) : (s == 1) ? (ox < w)
                                             : (ox >= 1 && ox - 1 < w);
            if (row_ok && col_ok) begin
               pix = window[(2 - r) * 3 + s];
               k = kernel_rows[r][12*s +: 12];
               for (int c = 0; c < 3; c++)
                  sum[c] += int'(k) * int'(pix[8*c +: 8]);
            end
         end
      end
      for (int c = 0; c < 3; c++) begin
         if (sum[c] < 0) chan[c] = 8'd0;
         else if ((sum[c] >>> FRAC_BITS) > 255) chan[c] = 8'd255;
         else chan[c] = 8'(sum[c] >>> FRAC_BITS);
      end
      expected_pixels.push_back('{chan[0], chan[1], chan[2], ox == w - 1 && oy == h - 1});
      pos = next_pos(out_col, out_row);
      out_col = pos[31:0];
      out_row = pos[63:32];
   endfunction

   function automatic void predict_request(logic kind, logic [7:0] r, logic [7:0] g,
                                           logic [7:0] b);
      if (kind == REQ_PIXEL) begin
         shift_in({b, g, r});
         lead_cnt++;
         pend_real++;
         if (lead_cnt > active_width() + 1) begin
            filter_out();
            lead_cnt--;
            pend_real--;
         end
      end else if (pend_real != 0) begin
         shift_in(24'd0);
         lead_cnt++;
         if (lead_cnt > active_width() + 1) begin
            filter_out();
            lead_cnt--;
            pend_real--;
            if (pend_real == 0) begin
               in_col = out_col;
               in_row = out_row;
               lead_cnt = 0;
            end
         end
      end
   endfunction

   function automatic void predictor_reset();
      width_reg = 11'd1024;
      height_reg = 13'd768;
      kernel_rows = '{36'd0, 36'd1048576, 36'd0};
      for (int i = 0; i < LINE_DEPTH; i++) begin
         upper_line[i] = '0;
         lower_line[i] = '0;
      end
      for (int i = 0; i < 9; i++) window[i] = '0;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0; lead_cnt = 0; pend_real = 0;
   endfunction

   function automatic logic [7:0] rand_chan();
      case ($urandom_range(0, 3))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [35:0] rand_kernel_row();
      logic [35:0] v;
      if ($urandom_range(0, 2) == 0) return 36'({$urandom, $urandom});
      for (int s = 0; s < 3; s++) v[12*s +: 12] = 12'($signed($urandom_range(0, 640)) - 320);
      return v;
   endfunction

   // called and returns at a falling edge
   task automatic send_request(logic kind, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_type = kind;
      req_in_red = r;
      req_in_green = g;
      req_in_blue = b;
      do @(posedge clock); while (!req_ready);
      predict_request(kind, r, g, b);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic send_pixel();
      send_request(REQ_PIXEL, rand_chan(), rand_chan(), rand_chan());
   endtask

   task automatic flush_pending();
      while (pend_real > 0) send_request(REQ_DRAIN, rand_chan(), rand_chan(), rand_chan());
   endtask

   task automatic wait_idle();
      while (expected_pixels.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      wait_idle();
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
      case (idx)
         CSR_FRAME_WIDTH:  width_reg = data[10:0];
         CSR_FRAME_HEIGHT: height_reg = data[12:0];
         CSR_TAPS_TOP:     kernel_rows[0] = data;
         CSR_TAPS_MIDDLE:  kernel_rows[1] = data;
         CSR_TAPS_BOTTOM:  kernel_rows[2] = data;
         default: ;
      endcase
   endtask

   task automatic set_kernel(logic [35:0] top, logic [35:0] mid, logic [35:0] bot);
      write_csr(CSR_TAPS_TOP, top);
      write_csr(CSR_TAPS_MIDDLE, mid);
      write_csr(CSR_TAPS_BOTTOM, bot);
   endtask

   task automatic set_frame(int w, int h);
      write_csr(CSR_FRAME_WIDTH, CSR_DATA_W'(w));
      write_csr(CSR_FRAME_HEIGHT, CSR_DATA_W'(h));
   endtask

   task automatic test_identity_small();
      send_request(REQ_DRAIN, 8'hff, 8'hff, 8'hff);   // nothing waiting
      set_frame(4, 3);
      send_request(REQ_PIXEL, 8'h00, 8'h00, 8'h00);
      send_request(REQ_PIXEL, 8'hff, 8'hff, 8'hff);
      send_request(REQ_PIXEL, 8'haa, 8'h55, 8'h0f);
      send_request(REQ_PIXEL, 8'h55, 8'haa, 8'hf0);
      repeat (8) send_pixel();
      flush_pending();
   endtask

   task automatic test_kernel_extremes();
      set_kernel({3{12'h7ff}}, {3{12'h7ff}}, {3{12'h7ff}});   // saturate high
      repeat (12) send_pixel();
      flush_pending();
      set_kernel({3{12'h800}}, {3{12'h800}}, {3{12'h800}});   // negative sums
      repeat (12) send_pixel();
      flush_pending();
      set_kernel(36'h001_002_004, 36'h008_010_020, 36'h040_080_100);
      repeat (12) send_pixel();
      flush_pending();
      write_csr(3'd5, '1);                                   // ignored indexes
      write_csr(3'd7, '0);
      set_frame(0, 0);
      repeat (3) send_pixel();
      flush_pending();
      set_frame(1, 1);
      repeat (3) send_pixel();
      flush_pending();
   endtask

   task automatic test_early_drain();
      set_kernel(rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
      set_frame(5, 4);
      repeat (9) send_pixel();
      repeat (3) send_request(REQ_DRAIN, 8'h00, 8'h00, 8'h00);
      repeat (4) send_pixel();                    // pixels during the flush
      flush_pending();
      repeat (20) send_pixel();
      flush_pending();
   endtask

   task automatic test_widest_frame();
      set_kernel(36'h000_100_000, 36'h100_000_100, 36'h000_100_000);
      set_frame(2047, 8191);
      repeat (30) send_pixel();
      flush_pending();
   endtask

   task automatic test_backpressure();
      set_kernel(rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
      set_frame(3, 4);
      send_idle_pct = 0;
      fork
         begin
            rsp_hold = 1;
            repeat (300) @(negedge clock);
            rsp_hold = 0;
         end
         repeat (40) send_pixel();
      join
      flush_pending();
   endtask

   task automatic test_random_frames(int items);
      int sent, n;
      sent = 0;
      while (sent < items) begin
         if ($urandom_range(0, 2) == 0) begin
            flush_pending();
            set_frame($urandom_range(1, 8), $urandom_range(1, 6));
            set_kernel(rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
         end
         n = active_width() * active_height();
         if ($urandom_range(0, 6) == 0) begin
            // broken frame: cut short, then some drains
            n = $urandom_range(0, n);
            repeat (n) send_pixel();
            repeat ($urandom_range(0, 12))
               send_request(REQ_DRAIN, rand_chan(), rand_chan(), rand_chan());
         end else begin
            repeat (n) send_pixel();
         end
         sent += n;
      end
      flush_pending();
   endtask

   // response side
   always @(negedge clock)
      rsp_ready <= !rsp_hold && ($urandom_range(0, 99) >= recv_idle_pct);

   always @(posedge clock) begin
      rgb_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h %h %h end=%b",
               rsp_out_red, rsp_out_green, rsp_out_blue, rsp_frame_end);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_out_red !== want.red || rsp_out_green !== want.green ||
                rsp_out_blue !== want.blue || rsp_frame_end !== want.frame_end) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h %h %h end=%b, got %h %h %h end=%b",
                     want.red, want.green, want.blue, want.frame_end,
                     rsp_out_red, rsp_out_green, rsp_out_blue, rsp_frame_end);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles > STALL_LIMIT) begin
         $display("FAIL rgb_convolution_3x3_unit");
         $finish;
      end
   end

   initial begin
      predictor_reset();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      send_idle_pct = 11;
      recv_idle_pct = 47;
      test_identity_small();
      test_kernel_extremes();
      test_early_drain();
      test_widest_frame();
      test_backpressure();
      send_idle_pct = 11;
      recv_idle_pct = 47;
      test_random_frames(80);
      send_idle_pct = 47;
      recv_idle_pct = 11;
      test_random_frames(80);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_frames(80);
      wait_idle();
      if (mismatches == 0 && expected_pixels.size() == 0)
         $display("PASS rgb_convolution_3x3_unit");
      else
         $display("FAIL rgb_convolution_3x3_unit");
      $finish;
   end

endmodule
